### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/was_pkg.sv
`timescale 1ns / 1ps
package was_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_BLACKOUT = 2'd0;
  localparam logic [1:0] CFG_BEEP     = 2'd1;
  localparam logic [1:0] CFG_AUTO_ACK = 2'd2;

  localparam logic [31:0] BLACKOUT_RST = 32'd30000;
  localparam logic [15:0] BEEP_RST     = 16'd1000;
  localparam logic [31:0] AUTO_ACK_RST = 32'd0;

  // Signed seconds-ahead arithmetic: hours and minutes up to 31/63 fit in 18 bits.
  localparam int AHEAD_W = 18;
  localparam logic signed [AHEAD_W-1:0] SEC_PER_HOUR = 18'sd3600;
  localparam logic signed [AHEAD_W-1:0] SEC_PER_MIN  = 18'sd60;
  localparam logic signed [AHEAD_W-1:0] AHEAD_LIMIT  = 18'sd100000;
  localparam logic signed [AHEAD_W-1:0] AHEAD_LATE   = -18'sd15;

  typedef struct packed {
    logic       enabled;
    logic [6:0] mask;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [3:0] sound;
  } alarm_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIRE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic scan_step;
    logic fire;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_fire;
    logic scan_last;
  } stat_t;

endpackage

### rtl/core/weekly_alarm_scheduler_core.sv
`timescale 1ns / 1ps
// Weekly alarm scheduler: an alarm table with a sequential soonest-alarm scan.
// Input channel: a transaction is taken when start is high and busy is low;
//   in_kind selects tick (time and milliseconds), entry write or acknowledge.
// Result channel: exactly one result per transaction, shown for one cycle
//   with out_strobe high; the receiver cannot stall, so it must take it then.
// Config port: cfg_we writes cfg_data to register cfg_index at once
//   (0 blackout, 1 beep interval, 2 auto acknowledge); write only while idle.
// Timing: busy stays high through execute and report (write, acknowledge,
//   blackout or sounding tick), through execute, fire check and report (tick
//   with no rescan) or through execute, the scan, fire check and report (tick
//   that rescans the table); the result strobe follows in the next cycle, and
//   a new start may be taken in that same cycle. The rescan reads one table
//   entry per cycle through the single read port, so it is the longest item.
// Reset: synchronous, active low; clears the table to disabled entries,
//   restores the register defaults and drops any sounding alarm.
module weekly_alarm_scheduler_core #(
  parameter int ALARM_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_now_ms,
  input  logic [4:0]  in_now_day,
  input  logic [2:0]  in_now_weekday,
  input  logic [4:0]  in_now_hour,
  input  logic [5:0]  in_now_minute,
  input  logic [2:0]  in_entry_index,
  input  logic        in_entry_enabled,
  input  logic [6:0]  in_entry_weekday_mask,
  input  logic [4:0]  in_entry_hour,
  input  logic [5:0]  in_entry_minute,
  input  logic [3:0]  in_entry_sound,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic        out_alarm_active,
  output logic [2:0]  out_due_index,
  output logic [3:0]  out_due_sound,
  output logic        out_fired,
  output logic        out_beep,
  output logic        out_display_inverted,
  output logic        out_auto_acked
);
  import was_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: capture, execute, optional scan, optional fire check, report.
  was_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table, scheduler state, config registers and result register.
  was_datapath #(
    .ALARM_COUNT (ALARM_COUNT)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_kind               (in_kind),
    .in_now_ms             (in_now_ms),
    .in_now_day            (in_now_day),
    .in_now_weekday        (in_now_weekday),
    .in_now_hour           (in_now_hour),
    .in_now_minute         (in_now_minute),
    .in_entry_index        (in_entry_index),
    .in_entry_enabled      (in_entry_enabled),
    .in_entry_weekday_mask (in_entry_weekday_mask),
    .in_entry_hour         (in_entry_hour),
    .in_entry_minute       (in_entry_minute),
    .in_entry_sound        (in_entry_sound),
    .out_strobe            (out_strobe),
    .out_alarm_active      (out_alarm_active),
    .out_due_index         (out_due_index),
    .out_due_sound         (out_due_sound),
    .out_fired             (out_fired),
    .out_beep              (out_beep),
    .out_display_inverted  (out_display_inverted),
    .out_auto_acked        (out_auto_acked)
  );

`include "assert_macros.svh"

  // Results are strobed only once the sequencer is back at idle.
  `ASSERT_IMPL(a_strobe_idle, out_strobe, !busy)
  // A taken transaction always occupies the sequencer in the next cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A fired alarm is sounding in the same result.
  `ASSERT_IMPL(a_fired_active, out_strobe && out_fired, out_alarm_active)
  // A timeout acknowledge leaves nothing sounding and the display normal.
  `ASSERT_IMPL(a_autoack_clear, out_strobe && out_auto_acked,
               !out_alarm_active && !out_display_inverted)

endmodule

### rtl/core/was_ctrl.sv
`timescale 1ns / 1ps
module was_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  was_pkg::stat_t stat,
  output was_pkg::cmd_t  cmd,
  output logic           busy
);
  import was_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.go_scan) state_nxt = ST_SCAN;
        else if (stat.go_fire) state_nxt = ST_FIRE;
        else state_nxt = ST_REPORT;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_FIRE;
      end
      ST_FIRE:   state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        cmd.cap = start;
      end
      ST_EXEC:   cmd.exec = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_FIRE:   cmd.fire = 1'b1;
      ST_REPORT: cmd.report = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

### rtl/core/was_datapath.sv
`timescale 1ns / 1ps
module was_datapath #(
  parameter int ALARM_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  was_pkg::cmd_t  cmd,
  output was_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic [1:0]     in_kind,
  input  logic [31:0]    in_now_ms,
  input  logic [4:0]     in_now_day,
  input  logic [2:0]     in_now_weekday,
  input  logic [4:0]     in_now_hour,
  input  logic [5:0]     in_now_minute,
  input  logic [2:0]     in_entry_index,
  input  logic           in_entry_enabled,
  input  logic [6:0]     in_entry_weekday_mask,
  input  logic [4:0]     in_entry_hour,
  input  logic [5:0]     in_entry_minute,
  input  logic [3:0]     in_entry_sound,
  output logic           out_strobe,
  output logic           out_alarm_active,
  output logic [2:0]     out_due_index,
  output logic [3:0]     out_due_sound,
  output logic           out_fired,
  output logic           out_beep,
  output logic           out_display_inverted,
  output logic           out_auto_acked
);
  import was_pkg::*;

  localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

  // configuration
  logic [31:0] blackout_r;
  logic [15:0] beep_interval_r;
  logic [31:0] auto_ack_r;

  // captured transaction
  kind_t        kind_q;
  logic [31:0]  now_q;
  logic [4:0]   day_q;
  logic [2:0]   wday_q;
  logic [4:0]   hour_q;
  logic [5:0]   minute_q;
  logic [2:0]   widx_q;
  alarm_entry_t wentry_q;

  // scheduler state
  alarm_entry_t table_r [ALARM_COUNT];
  logic                      next_valid_r;
  logic [IDX_W-1:0]          next_index_r;
  logic                      scan_valid_r;
  logic [4:0]                scanned_day_r;
  logic                      sounding_r;
  logic [IDX_W-1:0]          sounding_index_r;
  logic [31:0]               due_start_r;
  logic [31:0]               last_beep_r;
  logic                      beep_first_r;
  logic                      last_fire_valid_r;
  logic [4:0]                last_fire_day_r;
  logic [4:0]                last_fire_hour_r;
  logic [5:0]                last_fire_minute_r;
  logic                      invert_r;
  logic [IDX_W-1:0]          scan_cnt_r;
  logic signed [AHEAD_W-1:0] best_r;
  logic                      fired_r;
  logic                      beep_r;
  logic                      auto_acked_r;
  logic                      strobe_r;

  logic [IDX_W-1:0]          rd_addr;
  alarm_entry_t              rd_entry;
  logic                      tick_live;
  logic                      widx_ok;
  logic [IDX_W-1:0]          widx;
  logic                      beep_due;
  logic                      ack_due;
  logic [7:0]                mask_ext;
  logic                      day_match;
  logic                      skip_fired;
  logic signed [6:0]         dh;
  logic signed [7:0]         dm;
  logic signed [AHEAD_W-1:0] ahead;
  logic                      candidate;
  logic                      fire_now;

  // single table read port, address chosen by the active step
  always_comb begin
    if (cmd.scan_step) rd_addr = scan_cnt_r;
    else if (cmd.fire) rd_addr = next_index_r;
    else rd_addr = sounding_index_r;
  end
  assign rd_entry = table_r[rd_addr];

  assign tick_live = (kind_q == KIND_TICK) && (now_q >= blackout_r);
  assign widx_ok   = 32'(in_entry_index) < 32'(ALARM_COUNT) ? 1'b1 : 1'b0;
  assign widx      = IDX_W'(widx_q);
  assign beep_due  = beep_first_r || ((now_q - last_beep_r) > {16'b0, beep_interval_r});
  assign ack_due   = (auto_ack_r != 32'd0) && ((now_q - due_start_r) > auto_ack_r);

  assign stat.go_fire   = tick_live && !sounding_r;
  assign stat.go_scan   = tick_live && !sounding_r
                          && (!scan_valid_r || scanned_day_r != day_q);
  assign stat.scan_last = scan_cnt_r == IDX_W'(ALARM_COUNT - 1);

  // candidate test for the entry under the scan counter
  assign mask_ext   = {1'b0, rd_entry.mask};
  assign day_match  = (rd_entry.mask == 7'd0) || mask_ext[wday_q];
  assign skip_fired = last_fire_valid_r && (day_q == last_fire_day_r)
                      && (rd_entry.hour == last_fire_hour_r)
                      && (rd_entry.minute <= last_fire_minute_r);
  assign dh    = $signed({2'b00, rd_entry.hour}) - $signed({2'b00, hour_q});
  assign dm    = $signed({2'b00, rd_entry.minute}) - $signed({2'b00, minute_q});
  assign ahead = AHEAD_W'(dh) * SEC_PER_HOUR + AHEAD_W'(dm) * SEC_PER_MIN;
  assign candidate = rd_entry.enabled && day_match && !skip_fired
                     && (ahead > AHEAD_LATE) && (ahead < best_r);

  assign fire_now = next_valid_r && (rd_entry.hour == hour_q)
                    && (rd_entry.minute == minute_q);

  // capture the transaction; widx_ok is folded into the stored index check
  logic widx_ok_q;
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_q           <= kind_t'(in_kind);
      now_q            <= in_now_ms;
      day_q            <= in_now_day;
      wday_q           <= in_now_weekday;
      hour_q           <= in_now_hour;
      minute_q         <= in_now_minute;
      widx_q           <= in_entry_index;
      widx_ok_q        <= widx_ok;
      wentry_q.enabled <= in_entry_enabled;
      wentry_q.mask    <= in_entry_weekday_mask;
      wentry_q.hour    <= in_entry_hour;
      wentry_q.minute  <= in_entry_minute;
      wentry_q.sound   <= in_entry_sound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blackout_r      <= BLACKOUT_RST;
      beep_interval_r <= BEEP_RST;
      auto_ack_r      <= AUTO_ACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLACKOUT: blackout_r      <= cfg_data;
        CFG_BEEP:     beep_interval_r <= cfg_data[15:0];
        CFG_AUTO_ACK: auto_ack_r      <= cfg_data;
        default:      blackout_r      <= blackout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALARM_COUNT; i++) table_r[i] <= '0;
      next_valid_r       <= 1'b0;
      next_index_r       <= '0;
      scan_valid_r       <= 1'b0;
      scanned_day_r      <= '0;
      sounding_r         <= 1'b0;
      sounding_index_r   <= '0;
      due_start_r        <= '0;
      last_beep_r        <= '0;
      beep_first_r       <= 1'b0;
      last_fire_valid_r  <= 1'b0;
      last_fire_day_r    <= '0;
      last_fire_hour_r   <= '0;
      last_fire_minute_r <= '0;
      invert_r           <= 1'b0;
      scan_cnt_r         <= '0;
      best_r             <= AHEAD_LIMIT;
      fired_r            <= 1'b0;
      beep_r             <= 1'b0;
      auto_acked_r       <= 1'b0;
      strobe_r           <= 1'b0;
    end else begin
      strobe_r <= cmd.report;
      if (cmd.cap) begin
        fired_r      <= 1'b0;
        beep_r       <= 1'b0;
        auto_acked_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (kind_q)
          KIND_WRITE: begin
            if (widx_ok_q) begin
              table_r[widx] <= wentry_q;
              scan_valid_r  <= 1'b0;
            end
          end
          KIND_ACK: begin
            sounding_r   <= 1'b0;
            scan_valid_r <= 1'b0;
            invert_r     <= 1'b0;
          end
          KIND_TICK: begin
            if (tick_live && sounding_r) begin
              if (beep_due) begin
                last_beep_r  <= now_q;
                beep_first_r <= 1'b0;
                invert_r     <= !invert_r;
                beep_r       <= 1'b1;
              end
              // timeout wins over a toggle in the same step
              if (ack_due) begin
                sounding_r   <= 1'b0;
                scan_valid_r <= 1'b0;
                invert_r     <= 1'b0;
                auto_acked_r <= 1'b1;
              end
            end else if (stat.go_scan) begin
              next_valid_r  <= 1'b0;
              next_index_r  <= '0;
              best_r        <= AHEAD_LIMIT;
              scan_cnt_r    <= '0;
              scanned_day_r <= day_q;
              scan_valid_r  <= 1'b1;
            end
          end
          default: begin
            scan_cnt_r <= scan_cnt_r;
          end
        endcase
      end
      if (cmd.scan_step) begin
        if (candidate) begin
          best_r       <= ahead;
          next_valid_r <= 1'b1;
          next_index_r <= scan_cnt_r;
        end
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (cmd.fire && fire_now) begin
        sounding_r         <= 1'b1;
        sounding_index_r   <= next_index_r;
        due_start_r        <= now_q;
        last_fire_valid_r  <= 1'b1;
        last_fire_day_r    <= day_q;
        last_fire_hour_r   <= hour_q;
        last_fire_minute_r <= minute_q;
        beep_first_r       <= 1'b1;
        fired_r            <= 1'b1;
        if (rd_entry.mask == 7'd0) table_r[next_index_r].enabled <= 1'b0;
      end
    end
  end

  // result register, loaded in the report step
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_alarm_active     <= sounding_r;
      out_due_index        <= sounding_r ? 3'(sounding_index_r) : 3'd0;
      out_due_sound        <= sounding_r ? rd_entry.sound : 4'd0;
      out_fired            <= fired_r;
      out_beep             <= beep_r;
      out_display_inverted <= invert_r;
      out_auto_acked       <= auto_acked_r;
    end
  end

  assign out_strobe = strobe_r;

endmodule
